>>> hdl/lestm_pkg.sv
// Shared types, constants and arithmetic helpers for the log-exposure spline tone map.
package lestm_pkg;

   // Default parameter values
   localparam int DEF_MAX_KNOTS = 16;
   localparam int DEF_FRAC_BITS = 16;

   // Fixed arithmetic constants
   localparam logic signed [63:0] LOG10_2_Q30 = 64'sd323228497;
   localparam logic [30:0]        T_ONE       = 31'h4000_0000;
   localparam int                 EXTRA_BITS  = 16;
   localparam int                 LOG_STEPS   = 28;
   localparam logic signed [65:0] SAT62       = 66'sh4000000000000000;
   localparam logic [127:0]       SAT62_MAG   = 128'h4000000000000000;

   // Configuration register map
   localparam int         CSR_AW            = 5;
   localparam logic [2:0] REG_KNOTS_RED     = 3'd0;
   localparam logic [2:0] REG_KNOTS_GREEN   = 3'd1;
   localparam logic [2:0] REG_KNOTS_BLUE    = 3'd2;
   localparam logic [2:0] REG_BLACK_OFFSET  = 3'd3;
   localparam logic [2:0] REG_REF_LEVEL     = 3'd4;

   // Reset values
   localparam logic [4:0]  RST_KNOTS        = 5'd2;
   localparam logic [30:0] RST_BLACK_OFFSET = 31'd655;
   localparam logic [30:0] RST_REF_LEVEL    = 31'd65536;

   // Request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   // One spline knot as stored in a lane table
   typedef struct packed {
      logic signed [31:0] d;
      logic signed [31:0] y;
      logic signed [31:0] x;
   } knot_type;

   // Control from the merge stage to a lane
   typedef struct packed {
      logic start;
      logic ack;
   } lctl_type;

   typedef enum logic [1:0] {TP_IDLE, TP_RUN} tp_state_type;
   typedef enum logic [1:0] {LG_IDLE, LG_NORM, LG_SQ} lg_state_type;
   typedef enum logic [1:0] {MU_IDLE, MU_PP, MU_RND, MU_FIN} mu_state_type;
   typedef enum logic [0:0] {DV_IDLE, DV_RUN} dv_state_type;

   typedef enum logic [4:0] {
      LN_IDLE, LN_LOG, LN_EXP, LN_EXP_GOT, LN_MUL_W, LN_DIV_W, LN_RD0, LN_RD_LAST,
      LN_CHOOSE, LN_EXT_GOT, LN_SCAN, LN_SPAN, LN_T_GOT, LN_T2, LN_OM, LN_P0,
      LN_P0_GOT, LN_P1_GOT, LN_HT_GOT, LN_PM_GOT, LN_DM_GOT, LN_HN_GOT, LN_Q_GOT,
      LN_DONE
   } ln_state_type;

   function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic signed [65:0] sx66(input logic signed [63:0] v);
      return {{2{v[63]}}, v};
   endfunction

   // Clamp to magnitude 2^62
   function automatic logic signed [63:0] sat62(input logic signed [65:0] v);
      logic signed [65:0] r;
      if (v > SAT62) r = SAT62;
      else if (v < -SAT62) r = -SAT62;
      else r = v;
      return r[63:0];
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? (~v + 64'd1) : v;
   endfunction

endpackage

>>> hdl/log_exposure_spline_tone_map.sv
// Top level: request decode, configuration registers, three lanes and result merge.
//
// Each pixel request runs through three identical lanes (red, green, blue) at once.
// Pixels inside the knots also scan the table, one knot per cycle. The time of a
// pixel is set by the per-lane units: two iterative log2 units (one normalize
// shift per cycle, then 28 squarings), a 64x64 multiplier (four 32x32 partial
// products, round, saturate) used up to seven times, and a one-bit-a-cycle 64-bit
// divider used twice. A knot load request leaves the block idle, so another
// request may follow it straight away. The next request is taken
// as soon as all lanes have handed their result to the output register, even while
// that result still waits on rsp_tready. Knot tables hold no reset value: a knot must
// be loaded before any pixel reads it.
module log_exposure_spline_tone_map #(
   parameter int MAX_KNOTS = lestm_pkg::DEF_MAX_KNOTS,
   parameter int FRAC_BITS = lestm_pkg::DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // lane[1:0] knot_slot[5:2] knot_pos[37:6] knot_val[69:38] knot_deriv[101:70]
   // red_in[118:102] green_in[135:119] blue_in[152:136], zero pad above
   input  logic [159:0]                 req_tdata,
   input  logic                         req_tuser,  // kind
   input  logic                         req_tlast,  // frame_end
   // response channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // red_density[31:0] green_density[63:32] blue_density[95:64]
   output logic [95:0]                  rsp_tdata,
   output logic                         rsp_tlast,  // frame_last
   // configuration port
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lestm_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import lestm_pkg::*;

   localparam int IW = $clog2(MAX_KNOTS);

   tp_state_type state_ff, state_in;
   logic [4:0]  knots_ff [3];
   logic [30:0] black_ff, ref_ff;
   logic        rsp_valid_ff, rsp_valid_in, last_ff, last_in, frame_ff, frame_in;
   logic [95:0] dens_ff, dens_in;

   logic        accept, load_ok, csr_wr, merge;
   logic [2:0]  csr_idx;
   logic [1:0]  req_lane;
   logic [3:0]  req_slot;
   knot_type    req_knot;
   logic [16:0] samples [3];
   logic [2:0]  lane_done;
   logic signed [31:0] lane_dens [3];
   lctl_type    lctl;

   // request field unpack
   assign req_lane     = req_tdata[1:0];
   assign req_slot     = req_tdata[5:2];
   assign req_knot.x   = req_tdata[37:6];
   assign req_knot.y   = req_tdata[69:38];
   assign req_knot.d   = req_tdata[101:70];
   assign samples[0]   = req_tdata[118:102];
   assign samples[1]   = req_tdata[135:119];
   assign samples[2]   = req_tdata[152:136];

   assign req_tready = (state_ff == TP_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign load_ok    = accept && (req_tuser == KIND_LOAD) && (req_lane != 2'd3)
                       && ({28'd0, req_slot} < 32'(MAX_KNOTS));
   assign merge      = (state_ff == TP_RUN) && (&lane_done) && (!rsp_valid_ff || rsp_tready);
   assign lctl.start = accept && (req_tuser == KIND_PIXEL);
   assign lctl.ack   = merge;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      unique case (csr_idx)
         REG_KNOTS_RED:    csr_prdata = 32'(knots_ff[0]);
         REG_KNOTS_GREEN:  csr_prdata = 32'(knots_ff[1]);
         REG_KNOTS_BLUE:   csr_prdata = 32'(knots_ff[2]);
         REG_BLACK_OFFSET: csr_prdata = 32'(black_ff);
         REG_REF_LEVEL:    csr_prdata = 32'(ref_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         knots_ff[0] <= RST_KNOTS;
         knots_ff[1] <= RST_KNOTS;
         knots_ff[2] <= RST_KNOTS;
         black_ff    <= RST_BLACK_OFFSET;
         ref_ff      <= RST_REF_LEVEL;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_KNOTS_RED:    knots_ff[0] <= csr_pwdata[4:0];
            REG_KNOTS_GREEN:  knots_ff[1] <= csr_pwdata[4:0];
            REG_KNOTS_BLUE:   knots_ff[2] <= csr_pwdata[4:0];
            REG_BLACK_OFFSET: black_ff    <= csr_pwdata[30:0];
            REG_REF_LEVEL:    ref_ff      <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   // lanes
   for (genvar g = 0; g < 3; g++) begin : g_lane
      lestm_lane #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (lctl),
         .sample   (samples[g]),
         .black_off(black_ff),
         .ref_level(ref_ff),
         .knots    (knots_ff[g]),
         .we       (load_ok && (req_lane == 2'(g))),
         .waddr    (IW'(req_slot)),
         .wdata    (req_knot),
         .done     (lane_done[g]),
         .density  (lane_dens[g])
      );
   end

   // merge stage and output register
   always_comb begin
      state_in     = state_ff;
      frame_in     = frame_ff;
      rsp_valid_in = rsp_valid_ff;
      dens_in      = dens_ff;
      last_in      = last_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         TP_IDLE: begin
            if (lctl.start) begin
               frame_in = req_tlast;
               state_in = TP_RUN;
            end
         end
         TP_RUN: begin
            if (merge) begin
               rsp_valid_in = 1'b1;
               dens_in      = {lane_dens[2], lane_dens[1], lane_dens[0]};
               last_in      = frame_ff;
               state_in     = TP_IDLE;
            end
         end
         default: state_in = TP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_ff <= frame_in;
      dens_ff  <= dens_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = dens_ff;
   assign rsp_tlast  = last_ff;

endmodule

>>> hdl/lestm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lestm_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/lestm_log.sv
// Iterative log2 unit: normalize one bit a cycle, then one squaring per fraction bit.
module lestm_log (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] x,
   output logic        done,
   output logic [32:0] lg
);
   import lestm_pkg::*;

   lg_state_type state_ff, state_in;
   logic [31:0] xn_ff, xn_in;
   logic [4:0]  n_ff, n_in;
   logic [30:0] m_ff, m_in;
   logic [27:0] fr_ff, fr_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [61:0] sq;
   logic [31:0] m2;

   assign sq = m_ff * m_ff;
   assign m2 = sq[61:30];
   assign lg = {n_ff, fr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LG_IDLE;
      end else begin
         state_ff <= state_in;
      end
      xn_ff  <= xn_in;
      n_ff   <= n_in;
      m_ff   <= m_in;
      fr_ff  <= fr_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      xn_in    = xn_ff;
      n_in     = n_ff;
      m_in     = m_ff;
      fr_in    = fr_ff;
      cnt_in   = cnt_ff;
      done     = 1'b0;
      unique case (state_ff)
         LG_IDLE: begin
            if (start) begin
               xn_in    = x;
               n_in     = 5'd31;
               state_in = LG_NORM;
            end
         end
         // shift until the leading one sits at the top
         LG_NORM: begin
            if (xn_ff[31]) begin
               m_in     = xn_ff[31:1];
               fr_in    = '0;
               cnt_in   = '0;
               state_in = LG_SQ;
            end else begin
               xn_in = {xn_ff[30:0], 1'b0};
               n_in  = n_ff - 5'd1;
            end
         end
         // square the mantissa, one fraction bit per step
         LG_SQ: begin
            m_in   = m2[31] ? m2[31:1] : m2[30:0];
            fr_in  = {fr_ff[26:0], m2[31]};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(LOG_STEPS - 1)) begin
               done     = 1'b1;
               state_in = LG_IDLE;
            end
         end
         default: state_in = LG_IDLE;
      endcase
   end

endmodule

>>> hdl/lestm_mul.sv
// Sequential signed multiply with round-half-away shift and 2^62 saturation.
module lestm_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   input  logic [5:0]         sh,
   output logic               done,
   output logic signed [63:0] r
);
   import lestm_pkg::*;

   mu_state_type state_ff, state_in;
   logic [63:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic         neg_ff, neg_in;
   logic [5:0]   sh_ff, sh_in;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   step_ff, step_in;
   logic signed [63:0] r_ff, r_in;
   logic [31:0]  ap, bp;
   logic [63:0]  prod;
   logic [127:0] part, half;
   logic [63:0]  mg;

   assign ap   = step_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign bp   = step_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
   assign prod = ap * bp;
   assign half = (sh_ff == 6'd0) ? 128'd0 : (128'd1 << (sh_ff - 6'd1));
   assign mg   = (acc_ff > SAT62_MAG) ? SAT62_MAG[63:0] : acc_ff[63:0];
   assign r    = r_ff;

   // place the partial product by the halves it came from
   always_comb begin
      unique case (step_ff)
         2'd0:    part = {64'd0, prod};
         2'd3:    part = {prod, 64'd0};
         default: part = {32'd0, prod, 32'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MU_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      neg_ff  <= neg_in;
      sh_ff   <= sh_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      r_ff    <= r_in;
   end

   always_comb begin
      state_in = state_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      neg_in   = neg_ff;
      sh_in    = sh_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      r_in     = r_ff;
      done     = 1'b0;
      unique case (state_ff)
         MU_IDLE: begin
            if (start) begin
               ma_in    = mag64(a);
               mb_in    = mag64(b);
               neg_in   = a[63] ^ b[63];
               sh_in    = sh;
               acc_in   = '0;
               step_in  = '0;
               state_in = MU_PP;
            end
         end
         // one 32x32 partial product per cycle
         MU_PP: begin
            acc_in  = acc_ff + part;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) state_in = MU_RND;
         end
         MU_RND: begin
            acc_in   = (acc_ff + half) >> sh_ff;
            state_in = MU_FIN;
         end
         MU_FIN: begin
            r_in     = neg_ff ? $signed(~mg + 64'd1) : $signed(mg);
            done     = 1'b1;
            state_in = MU_IDLE;
         end
         default: state_in = MU_IDLE;
      endcase
   end

endmodule

>>> hdl/lestm_div.sv
// Restoring unsigned 64-bit divider, one quotient bit per cycle.
module lestm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] q
);
   import lestm_pkg::*;

   dv_state_type state_ff, state_in;
   logic [63:0] num_ff, num_in, den_ff, den_in, rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [64:0] rsh;
   logic        fit;

   assign rsh = {rem_ff, num_ff[63]};
   assign fit = rsh >= {1'b0, den_ff};
   assign q   = num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done     = 1'b0;
      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               num_in   = num;
               den_in   = den;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = DV_RUN;
            end
         end
         // quotient bits shift into the numerator register
         DV_RUN: begin
            rem_in = fit ? 64'(rsh - {1'b0, den_ff}) : rsh[63:0];
            num_in = {num_ff[62:0], fit};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               done     = 1'b1;
               state_in = DV_IDLE;
            end
         end
         default: state_in = DV_IDLE;
      endcase
   end

endmodule

>>> hdl/lestm_lane.sv
// One color lane: log exposure, knot search and rational quadratic spline evaluation.
module lestm_lane #(
   parameter int MAX_KNOTS = lestm_pkg::DEF_MAX_KNOTS,
   parameter int FRAC_BITS = lestm_pkg::DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lestm_pkg::lctl_type          ctl,
   input  logic [16:0]                  sample,
   input  logic [30:0]                  black_off,
   input  logic [30:0]                  ref_level,
   input  logic [4:0]                   knots,
   input  logic                         we,
   input  logic [$clog2(MAX_KNOTS)-1:0] waddr,
   input  lestm_pkg::knot_type          wdata,
   output logic                         done,
   output logic signed [31:0]           density
);
   import lestm_pkg::*;

   localparam int IW = $clog2(MAX_KNOTS);
   localparam int UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam logic [5:0] SH_F = 6'(FRAC_BITS);
   localparam logic [5:0] SH_E = 6'(58 - FRAC_BITS);
   localparam logic [5:0] SH_P = 6'(30 - EXTRA_BITS);
   localparam logic [5:0] SH_0 = 6'd0;

   ln_state_type state_ff, state_in, ret_ff, ret_in;
   logic fa_ff, fa_in, fb_ff, fb_in, neg_ff, neg_in;
   logic signed [63:0] e_ff, e_in, base_ff, base_in, w_ff, w_in, h_ff, h_in;
   logic signed [63:0] p0_ff, p0_in, p1_ff, p1_in, acc_ff, acc_in;
   logic signed [63:0] n_ff, n_in, dn_ff, dn_in, res_ff, res_in;
   knot_type lo_ff, lo_in, hi_ff, hi_in, rd;
   logic [IW-1:0] idx_ff, idx_in, rd_addr, last_idx;
   logic [30:0] t_ff, t_in, t2_ff, t2_in, om_ff, om_in, sq_b;
   logic [61:0] sq;

   // unit handshakes
   logic        log_go, da, db, mul_go, mul_done, div_go, div_done;
   logic [32:0] la, lb;
   logic [31:0] s_num, s_den, s_scaled;
   logic [30:0] bo;
   logic signed [63:0] mul_a, mul_b, mul_r;
   logic [5:0]  mul_sh;
   logic [63:0] div_num, div_den, div_q;
   logic [$bits(knot_type)-1:0] rdata;

   // datapath temporaries
   logic signed [33:0] diff;
   logic signed [63:0] rx, lx, ly, e_lo, e_rd, w_c, dn0, dnc, nsum;
   logic [63:0] mhn, mdn;

   // last knot index in use, clamped to the table
   always_comb begin
      if (knots < 5'd2) begin
         last_idx = IW'(1);
      end else if ({27'd0, knots} > 32'(MAX_KNOTS)) begin
         last_idx = IW'(MAX_KNOTS - 1);
      end else begin
         last_idx = IW'(knots - 5'd1);
      end
   end

   // log operands
   assign bo       = (black_off == 31'd0) ? 31'd1 : black_off;
   assign s_scaled = (32'(sample) << UP) >> DN;
   assign s_num    = s_scaled + 32'(bo);
   assign s_den    = 32'(ref_level) + 32'(bo);
   assign diff     = $signed({1'b0, la}) - $signed({1'b0, lb});

   assign rd   = knot_type'(rdata);
   assign rx   = sx64(rd.x);
   assign lx   = sx64(lo_ff.x);
   assign ly   = sx64(lo_ff.y);
   assign e_lo = e_ff - lx;
   assign e_rd = e_ff - rx;
   assign w_c  = sx64(hi_ff.x) - lx;
   assign sq_b = (state_ff == LN_OM) ? (T_ONE - t_ff) : t_ff;
   assign sq   = t_ff * sq_b;
   assign nsum = sat62(sx66(acc_ff) + sx66(mul_r));
   assign dn0  = sat62(sx66(sat62(sx66(p0_ff) + sx66(p1_ff))) - (sx66(h_ff) <<< 1));
   assign dnc  = sat62((sx66(h_ff) <<< EXTRA_BITS) + sx66(mul_r));
   assign mhn  = mag64(mul_r);
   assign mdn  = mag64(dn_ff);

   lestm_log u_log_num (
      .clock(clock), .reset(reset), .start(log_go), .x(s_num), .done(da), .lg(la)
   );
   lestm_log u_log_den (
      .clock(clock), .reset(reset), .start(log_go), .x(s_den), .done(db), .lg(lb)
   );
   lestm_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_go), .a(mul_a), .b(mul_b), .sh(mul_sh),
      .done(mul_done), .r(mul_r)
   );
   lestm_div u_div (
      .clock(clock), .reset(reset), .start(div_go), .num(div_num), .den(div_den),
      .done(div_done), .q(div_q)
   );
   lestm_ram #(.WIDTH($bits(knot_type)), .DEPTH(MAX_KNOTS)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata), .raddr(rd_addr), .rdata(rdata)
   );

   // saturate the result to 32 bits
   always_comb begin
      if (res_ff > 64'sd2147483647) begin
         density = 32'sh7FFFFFFF;
      end else if (res_ff < -64'sd2147483648) begin
         density = 32'sh80000000;
      end else begin
         density = res_ff[31:0];
      end
   end

   assign done = (state_ff == LN_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LN_IDLE;
         ret_ff   <= LN_IDLE;
         fa_ff    <= 1'b0;
         fb_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fa_ff    <= fa_in;
         fb_ff    <= fb_in;
      end
      neg_ff  <= neg_in;
      e_ff    <= e_in;
      base_ff <= base_in;
      w_ff    <= w_in;
      h_ff    <= h_in;
      p0_ff   <= p0_in;
      p1_ff   <= p1_in;
      acc_ff  <= acc_in;
      n_ff    <= n_in;
      dn_ff   <= dn_in;
      res_ff  <= res_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      idx_ff  <= idx_in;
      t_ff    <= t_in;
      t2_ff   <= t2_in;
      om_ff   <= om_in;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      fa_in    = fa_ff;
      fb_in    = fb_ff;
      neg_in   = neg_ff;
      e_in     = e_ff;
      base_in  = base_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      p0_in    = p0_ff;
      p1_in    = p1_ff;
      acc_in   = acc_ff;
      n_in     = n_ff;
      dn_in    = dn_ff;
      res_in   = res_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      idx_in   = idx_ff;
      t_in     = t_ff;
      t2_in    = t2_ff;
      om_in    = om_ff;
      rd_addr  = idx_ff;
      log_go   = 1'b0;
      mul_go   = 1'b0;
      mul_a    = '0;
      mul_b    = '0;
      mul_sh   = SH_0;
      div_go   = 1'b0;
      div_num  = '0;
      div_den  = '0;
      unique case (state_ff)
         LN_IDLE: begin
            if (ctl.start) begin
               log_go   = 1'b1;
               fa_in    = 1'b0;
               fb_in    = 1'b0;
               state_in = LN_LOG;
            end
         end
         LN_LOG: begin
            fa_in = fa_ff | da;
            fb_in = fb_ff | db;
            if ((fa_ff | da) && (fb_ff | db)) state_in = LN_EXP;
         end
         // exposure = log2 ratio times log10(2)
         LN_EXP: begin
            mul_go   = 1'b1;
            mul_a    = {{30{diff[33]}}, diff};
            mul_b    = LOG10_2_Q30;
            mul_sh   = SH_E;
            ret_in   = LN_EXP_GOT;
            state_in = LN_MUL_W;
         end
         LN_MUL_W: begin
            if (mul_done) state_in = ret_ff;
         end
         LN_DIV_W: begin
            if (div_done) state_in = ret_ff;
         end
         LN_EXP_GOT: begin
            e_in     = mul_r;
            state_in = LN_RD0;
         end
         LN_RD0: begin
            rd_addr  = '0;
            state_in = LN_RD_LAST;
         end
         LN_RD_LAST: begin
            lo_in    = rd;
            rd_addr  = last_idx;
            state_in = LN_CHOOSE;
         end
         // below, above or inside the knots
         LN_CHOOSE: begin
            if (e_ff < lx) begin
               mul_go   = 1'b1;
               mul_a    = sx64(lo_ff.d);
               mul_b    = e_lo;
               mul_sh   = SH_F;
               base_in  = ly;
               ret_in   = LN_EXT_GOT;
               state_in = LN_MUL_W;
            end else if (e_ff > rx) begin
               mul_go   = 1'b1;
               mul_a    = sx64(rd.d);
               mul_b    = e_rd;
               mul_sh   = SH_F;
               base_in  = sx64(rd.y);
               ret_in   = LN_EXT_GOT;
               state_in = LN_MUL_W;
            end else begin
               idx_in   = IW'(1);
               rd_addr  = IW'(1);
               state_in = LN_SCAN;
            end
         end
         LN_EXT_GOT: begin
            res_in   = base_ff + mul_r;
            state_in = LN_DONE;
         end
         // walk the knots one read a cycle
         LN_SCAN: begin
            if ((e_ff >= rx) && (idx_ff < last_idx)) begin
               lo_in   = rd;
               idx_in  = idx_ff + IW'(1);
               rd_addr = idx_ff + IW'(1);
            end else begin
               hi_in    = rd;
               state_in = LN_SPAN;
            end
         end
         LN_SPAN: begin
            if (w_c <= 64'sd0) begin
               res_in   = ly;
               state_in = LN_DONE;
            end else begin
               w_in     = w_c;
               h_in     = sx64(hi_ff.y) - ly;
               div_go   = 1'b1;
               div_num  = e_lo << 30;
               div_den  = w_c;
               ret_in   = LN_T_GOT;
               state_in = LN_DIV_W;
            end
         end
         LN_T_GOT: begin
            t_in     = (div_q > 64'(T_ONE)) ? T_ONE : div_q[30:0];
            state_in = LN_T2;
         end
         LN_T2: begin
            t2_in    = sq[60:30];
            state_in = LN_OM;
         end
         LN_OM: begin
            om_in    = sq[60:30];
            state_in = LN_P0;
         end
         LN_P0: begin
            mul_go   = 1'b1;
            mul_a    = w_ff;
            mul_b    = sx64(lo_ff.d);
            mul_sh   = SH_F;
            ret_in   = LN_P0_GOT;
            state_in = LN_MUL_W;
         end
         LN_P0_GOT: begin
            p0_in    = mul_r;
            mul_go   = 1'b1;
            mul_a    = w_ff;
            mul_b    = sx64(hi_ff.d);
            mul_sh   = SH_F;
            ret_in   = LN_P1_GOT;
            state_in = LN_MUL_W;
         end
         LN_P1_GOT: begin
            p1_in    = mul_r;
            mul_go   = 1'b1;
            mul_a    = h_ff;
            mul_b    = 64'(t2_ff);
            mul_sh   = SH_P;
            ret_in   = LN_HT_GOT;
            state_in = LN_MUL_W;
         end
         LN_HT_GOT: begin
            acc_in   = mul_r;
            mul_go   = 1'b1;
            mul_a    = p0_ff;
            mul_b    = 64'(om_ff);
            mul_sh   = SH_P;
            ret_in   = LN_PM_GOT;
            state_in = LN_MUL_W;
         end
         // numerator done; start the denominator slope term
         LN_PM_GOT: begin
            n_in     = nsum;
            mul_go   = 1'b1;
            mul_a    = dn0;
            mul_b    = 64'(om_ff);
            mul_sh   = SH_P;
            ret_in   = LN_DM_GOT;
            state_in = LN_MUL_W;
         end
         LN_DM_GOT: begin
            dn_in = dnc;
            if (dnc == 64'sd0) begin
               res_in   = ly;
               state_in = LN_DONE;
            end else begin
               mul_go   = 1'b1;
               mul_a    = h_ff;
               mul_b    = n_ff;
               mul_sh   = SH_0;
               ret_in   = LN_HN_GOT;
               state_in = LN_MUL_W;
            end
         end
         // rounded quotient on magnitudes
         LN_HN_GOT: begin
            neg_in   = mul_r[63] ^ dn_ff[63];
            div_go   = 1'b1;
            div_num  = mhn + (mdn >> 1);
            div_den  = mdn;
            ret_in   = LN_Q_GOT;
            state_in = LN_DIV_W;
         end
         LN_Q_GOT: begin
            res_in   = neg_ff ? (ly - $signed(div_q)) : (ly + $signed(div_q));
            state_in = LN_DONE;
         end
         LN_DONE: begin
            if (ctl.ack) state_in = LN_IDLE;
         end
         default: state_in = LN_IDLE;
      endcase
   end

endmodule
